@@ src/set_assoc_cache_tag_lookup_assert.svh @@
// assertion macros shared by the tag lookup block
`ifndef SET_ASSOC_CACHE_TAG_LOOKUP_ASSERT_SVH
`define SET_ASSOC_CACHE_TAG_LOOKUP_ASSERT_SVH

// same-cycle implication
`define SACL_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SACL_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/sacl_pkg.sv @@
`default_nettype none

package sacl_pkg;

   // fixed field widths of the request and response words
   localparam int WAY_FIELD_W = 3;
   localparam int HIT_TOTAL_W = 32;
   localparam int VICTIM_CODES = 2 ** WAY_FIELD_W;

   // widest way index over the supported associativity
   localparam int MAX_WAY_W = 4;

   // request type codes
   localparam logic REQ_READ  = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   typedef struct packed {
      logic                 hit;
      logic [MAX_WAY_W-1:0] way;
   } sacl_match_type;

endpackage

`default_nettype wire

@@ src/sacl_ram.sv @@
`default_nettype none

module sacl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ src/sacl_match.sv @@
`default_nettype none

module sacl_match
   import sacl_pkg::*;
#(
   parameter int WAYS  = 8,
   parameter int TAG_W = 30
) (
   input  logic [WAYS*(TAG_W+1)-1:0] row,
   input  logic [TAG_W-1:0]          tag,
   output sacl_match_type            result
);

   localparam int ENTRY_W = TAG_W + 1;

   // lowest matching way wins, so scan from the top down
   always_comb begin
      result = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (row[w*ENTRY_W + TAG_W] && (row[w*ENTRY_W +: TAG_W] == tag)) begin
            result.hit = 1'b1;
            result.way = MAX_WAY_W'(w);
         end
      end
   end

endmodule

`default_nettype wire

@@ src/set_assoc_cache_tag_lookup.sv @@
`default_nettype none

`include "set_assoc_cache_tag_lookup_assert.svh"

// Tag and valid controller of a set-associative, write-through, no-write-allocate
// cache. A request is taken when start is high and busy is low; its response is
// registered after the tag RAM read and the lookup state, then appears on the rsp_
// ports for exactly one cycle with rsp_valid high, and the receiver cannot stall
// it. A request first reads the set's row (tags and valid bits of all ways) from
// the single-port-read tag RAM, then compares all ways in parallel and writes the
// row back on a read miss. A new request may start in the cycle its predecessor's
// response is shown, not earlier, as busy is high during the lookup. After reset
// the block sweeps the tag RAM to clear the valid bits of every set, one set per
// cycle, with busy high. SETS and BLOCK_BYTES must be powers of two, and ADDR_BITS
// must exceed the offset and set index bits.
module set_assoc_cache_tag_lookup
   import sacl_pkg::*;
#(
   parameter int WAYS        = 8,
   parameter int SETS        = 64,
   parameter int BLOCK_BYTES = 16,
   parameter int ADDR_BITS   = 40
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [ADDR_BITS-1:0]   req_address,
   input  logic                   req_req_type,
   input  logic [WAY_FIELD_W-1:0] req_victim_way,
   output logic                   rsp_valid,
   output logic                   rsp_hit,
   output logic [WAY_FIELD_W-1:0] rsp_way,
   output logic                   rsp_filled,
   output logic                   rsp_memory_read,
   output logic                   rsp_memory_write,
   output logic [HIT_TOTAL_W-1:0] rsp_hit_total
);

   localparam int OFF_W   = $clog2(BLOCK_BYTES);
   localparam int SET_W   = $clog2(SETS);
   localparam int TAG_W   = ADDR_BITS - OFF_W - SET_W;
   localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int ENTRY_W = TAG_W + 1;
   localparam int ROW_W   = WAYS * ENTRY_W;

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_LOOKUP = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [SET_W-1:0]       clr_idx_ff, clr_idx_in;
   logic [SET_W-1:0]       set_ff, set_in;
   logic [TAG_W-1:0]       tag_ff, tag_in;
   logic                   write_ff, write_in;
   logic [WAY_W-1:0]       victim_ff, victim_in;
   logic [HIT_TOTAL_W-1:0] hit_cnt_ff, hit_cnt_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_hit_ff, rsp_hit_in;
   logic [WAY_FIELD_W-1:0] rsp_way_ff, rsp_way_in;
   logic                   rsp_filled_ff, rsp_filled_in;
   logic                   rsp_memory_read_ff, rsp_memory_read_in;
   logic                   rsp_memory_write_ff, rsp_memory_write_in;

   logic                   accept;
   logic                   lookup;
   logic                   fill;
   logic [WAY_W-1:0]       victim_map [VICTIM_CODES];
   logic [ROW_W-1:0]       rd_row;
   logic [ROW_W-1:0]       fill_row;
   logic                   ram_wr_en;
   logic [SET_W-1:0]       ram_wr_addr;
   logic [ROW_W-1:0]       ram_wr_data;
   sacl_match_type         match;

   // victim codes beyond the way count wrap modulo WAYS
   for (genvar v = 0; v < VICTIM_CODES; v++) begin : g_victim
      assign victim_map[v] = WAY_W'(v % WAYS);
   end

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign lookup = (state_ff == ST_LOOKUP);
   assign fill   = lookup && !match.hit && !write_ff;

   sacl_ram #(
      .WIDTH (ROW_W),
      .DEPTH (SETS)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (req_address[OFF_W +: SET_W]),
      .rd_data (rd_row)
   );

   sacl_match #(
      .WAYS  (WAYS),
      .TAG_W (TAG_W)
   ) u_match (
      .row    (rd_row),
      .tag    (tag_ff),
      .result (match)
   );

   // row with the victim way replaced by the new tag, marked valid
   always_comb begin
      fill_row = rd_row;
      for (int w = 0; w < WAYS; w++) begin
         if (WAY_W'(w) == victim_ff) begin
            fill_row[w*ENTRY_W +: ENTRY_W] = {1'b1, tag_ff};
         end
      end
   end

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = set_ff;
      ram_wr_data = fill_row;
      if (state_ff == ST_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_idx_ff;
         ram_wr_data = '0;
      end else if (fill) begin
         ram_wr_en = 1'b1;
      end
   end

   always_comb begin
      state_in   = state_ff;
      clr_idx_in = clr_idx_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_idx_in = clr_idx_ff + 1'b1;
            if (clr_idx_ff == SET_W'(SETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      set_in    = set_ff;
      tag_in    = tag_ff;
      write_in  = write_ff;
      victim_in = victim_ff;
      if (accept) begin
         set_in    = req_address[OFF_W +: SET_W];
         tag_in    = req_address[OFF_W + SET_W +: TAG_W];
         write_in  = (req_req_type == REQ_WRITE);
         victim_in = victim_map[req_victim_way];
      end
   end

   always_comb begin
      hit_cnt_in = hit_cnt_ff;
      if (lookup && match.hit && (hit_cnt_ff != '1)) begin
         hit_cnt_in = hit_cnt_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in        = lookup;
      rsp_hit_in          = match.hit;
      rsp_filled_in       = fill;
      rsp_memory_read_in  = fill;
      rsp_memory_write_in = write_ff;
      if (match.hit) begin
         rsp_way_in = match.way[WAY_FIELD_W-1:0];
      end else if (!write_ff) begin
         rsp_way_in = WAY_FIELD_W'(victim_ff);
      end else begin
         rsp_way_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         hit_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         hit_cnt_ff   <= hit_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      set_ff              <= set_in;
      tag_ff              <= tag_in;
      write_ff            <= write_in;
      victim_ff           <= victim_in;
      rsp_hit_ff          <= rsp_hit_in;
      rsp_way_ff          <= rsp_way_in;
      rsp_filled_ff       <= rsp_filled_in;
      rsp_memory_read_ff  <= rsp_memory_read_in;
      rsp_memory_write_ff <= rsp_memory_write_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_way          = rsp_way_ff;
   assign rsp_filled       = rsp_filled_ff;
   assign rsp_memory_read  = rsp_memory_read_ff;
   assign rsp_memory_write = rsp_memory_write_ff;
   assign rsp_hit_total    = hit_cnt_ff;

   `SACL_ASSERT_NEXT(a_accept_to_lookup, clock, reset, accept, state_ff == ST_LOOKUP, "accepted word did not enter lookup")
   `SACL_ASSERT_NEXT(a_lookup_to_resp, clock, reset, lookup, rsp_valid_ff && (state_ff == ST_IDLE), "lookup did not produce a response")
   `SACL_ASSERT_IMP(a_fill_shape, clock, reset, rsp_valid_ff && rsp_filled_ff, !rsp_hit_ff && rsp_memory_read_ff && !rsp_memory_write_ff, "fill response with bad flags")
   `SACL_ASSERT_NEXT(a_count_mono, clock, reset, 1'b1, hit_cnt_ff >= $past(hit_cnt_ff), "hit count went down")

endmodule

`default_nettype wire
